// ===== sv/ubbr_pkg.sv =====
// ----------------------------------------------------------------------------
// ubbr_pkg
// Shared types, codes and sizes for the serial block boot receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ubbr_pkg;

   // Bytes in one transfer block
   localparam int BLOCK_BYTES = 64;
   localparam int BIB_W       = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam logic [BIB_W-1:0] BIB_LAST = BIB_W'(BLOCK_BYTES - 1);

   // Field widths
   localparam int CMD_W     = 2;
   localparam int DATA_W    = 8;
   localparam int REPLY_W   = 2;
   localparam int COUNT_W   = 16;
   localparam int TIMEOUT_W = 16;
   localparam int NAK_W     = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   // Register reset values
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = TIMEOUT_W'(15 * 1000);
   localparam logic [NAK_W-1:0]     NAK_LIMIT_RESET = NAK_W'(3);
   localparam logic [COUNT_W-1:0]   IDLE_MAX        = '1;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   // Reply codes
   localparam logic [REPLY_W-1:0] REPLY_NONE = 2'd0;
   localparam logic [REPLY_W-1:0] REPLY_ACK  = 2'd1;
   localparam logic [REPLY_W-1:0] REPLY_NAK  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NAK_LIMIT = 1'd1;

   // One request as held in the input register
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] data;
   } req_type;

   // One result
   typedef struct packed {
      logic               data_valid;
      logic [DATA_W-1:0]  data_out;
      logic               block_end;
      logic [REPLY_W-1:0] reply;
      logic               failed;
      logic [COUNT_W-1:0] blocks_done;
   } rsp_type;

   // Handshake between the input register and the result register
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_type;

endpackage

`default_nettype wire

// ===== sv/ubbr_if.sv =====
// ----------------------------------------------------------------------------
// ubbr_if
// Channel interfaces: request, result and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface ubbr_req_if import ubbr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [DATA_W-1:0] data;

   modport source (output valid, cmd, data, input ready);
   modport sink   (input valid, cmd, data, output ready);
endinterface

interface ubbr_rsp_if import ubbr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               data_valid;
   logic [DATA_W-1:0]  data_out;
   logic               block_end;
   logic [REPLY_W-1:0] reply;
   logic               failed;
   logic [COUNT_W-1:0] blocks_done;

   modport source (output valid, data_valid, data_out, block_end, reply, failed,
                   blocks_done, input ready);
   modport sink   (input valid, data_valid, data_out, block_end, reply, failed,
                   blocks_done, output ready);
endinterface

interface ubbr_csr_if import ubbr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== sv/uart_block_boot_receiver_core.sv =====
// ----------------------------------------------------------------------------
// uart_block_boot_receiver_core
// Serial block boot receiver: start, byte and tick requests in, one result
// per request out.
//
// Channels: req_ch takes one request (cmd, data) per accepted handshake;
// rsp_ch returns exactly one result per request, in order; csr_ch writes
// timeout_ticks (index 0) and nak_limit (index 1) and is always ready.
// Path: a request passes the input register, then the state update logic,
// then the result register.
// Throughput: one request per cycle while rsp_ch does not stall; the state
// loop closes through the engine's counters, so back-to-back requests see
// the state left by the one before.
// Reset: both registers empty, receiver not armed, counts cleared,
// timeout 15000 ticks and nak limit 3.
// Stall: while rsp_ch.ready is low the result is held, one more request is
// taken into the input register, and req_ch.ready then drops until the
// result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_block_boot_receiver_core import ubbr_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   ubbr_req_if.sink   req_ch,
   ubbr_rsp_if.source rsp_ch,
   ubbr_csr_if.sink   csr_ch
);

   stage_type stage;
   req_type   req_q;
   rsp_type   result;
   logic      out_free;

   ubbr_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .out_free (out_free),
      .stage    (stage),
      .req_q    (req_q)
   );

   ubbr_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .stage  (stage),
      .req_q  (req_q),
      .result (result)
   );

   ubbr_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .result   (result),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

   // An ack only comes with the byte that closes a block
   a_ack_block: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.reply == REPLY_ACK |-> rsp_ch.block_end && rsp_ch.data_valid)
      else $error("ack without a block end");

   // A failed transfer passes no bytes and requests no nak
   a_fail_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.failed |-> !rsp_ch.data_valid && rsp_ch.reply != REPLY_NAK)
      else $error("activity after failure");

   // Result register is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

   // A request cannot be taken while the pipeline is full and stalled
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      stage.valid && rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while full");

endmodule

`default_nettype wire

// ===== sv/ubbr_in_stage.sv =====
// ----------------------------------------------------------------------------
// ubbr_in_stage
// Input register: captures one request per cycle while the next stage moves.
// ----------------------------------------------------------------------------
`default_nettype none

module ubbr_in_stage import ubbr_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   ubbr_req_if.sink       req_ch,
   input  wire logic      out_free,
   output stage_type      stage,
   output req_type        req_q
);

   logic    valid_ff, valid_in;
   req_type req_ff, req_in;
   logic    advance;

   // Request leaves when the result register can take it
   assign advance       = valid_ff && out_free;
   assign req_ch.ready  = !valid_ff || out_free;
   assign stage.valid   = valid_ff;
   assign stage.advance = advance;
   assign req_q         = req_ff;

   // Load a new request or drain the held one
   always_comb begin
      valid_in = valid_ff;
      req_in   = req_ff;
      if (req_ch.valid && req_ch.ready) begin
         valid_in   = 1'b1;
         req_in.cmd  = req_ch.cmd;
         req_in.data = req_ch.data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      req_ff <= req_in;
   end

endmodule

`default_nettype wire

// ===== sv/ubbr_engine.sv =====
// ----------------------------------------------------------------------------
// ubbr_engine
// Transfer state, configuration registers and the per-request result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ubbr_engine import ubbr_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   ubbr_csr_if.sink       csr_ch,
   input  wire stage_type stage,
   input  wire req_type   req_q,
   output rsp_type        result
);

   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [NAK_W-1:0]     nak_limit_ff;

   logic                 armed_ff, armed_in;
   logic                 fail_ff, fail_in;
   logic [BIB_W-1:0]     bib_ff, bib_in;
   logic [COUNT_W-1:0]   blocks_ff, blocks_in;
   logic [COUNT_W-1:0]   idle_ff, idle_in;
   logic [NAK_W-1:0]     naks_ff, naks_in;

   logic                 running;
   logic [COUNT_W-1:0]   idle_inc;
   logic [NAK_W-1:0]     naks_inc;

   assign csr_ch.ready = 1'b1;

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         nak_limit_ff <= NAK_LIMIT_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_TIMEOUT:   timeout_ff   <= csr_ch.wdata[TIMEOUT_W-1:0];
            REG_NAK_LIMIT: nak_limit_ff <= csr_ch.wdata[NAK_W-1:0];
            default:       ;
         endcase
      end
   end

   assign running  = armed_ff && !fail_ff;
   assign idle_inc = (idle_ff != IDLE_MAX) ? idle_ff + 1'b1 : idle_ff;
   assign naks_inc = naks_ff + 1'b1;

   // Work out the result and the next state for the held request
   always_comb begin
      armed_in  = armed_ff;
      fail_in   = fail_ff;
      bib_in    = bib_ff;
      blocks_in = blocks_ff;
      idle_in   = idle_ff;
      naks_in   = naks_ff;
      result    = '0;
      unique case (req_q.cmd)
         CMD_START: begin
            armed_in  = 1'b1;
            fail_in   = 1'b0;
            bib_in    = '0;
            blocks_in = '0;
            idle_in   = '0;
            naks_in   = '0;
         end
         CMD_BYTE: begin
            if (running) begin
               result.data_valid = 1'b1;
               result.data_out   = req_q.data;
               idle_in           = '0;
               naks_in           = '0;
               if (bib_ff == BIB_LAST) begin
                  bib_in           = '0;
                  blocks_in        = blocks_ff + 1'b1;
                  result.block_end = 1'b1;
                  result.reply     = REPLY_ACK;
               end else begin
                  bib_in = bib_ff + 1'b1;
               end
            end
         end
         CMD_TICK: begin
            if (running) begin
               idle_in = idle_inc;
               if (idle_inc >= timeout_ff) begin
                  idle_in = '0;
                  naks_in = naks_inc;
                  if (naks_inc >= nak_limit_ff) begin
                     fail_in = 1'b1;
                  end else begin
                     result.reply = REPLY_NAK;
                  end
               end
            end
         end
         CMD_SPARE: ;
         default:   ;
      endcase
      result.failed      = fail_in;
      result.blocks_done = blocks_in;
   end

   // Advance the state with each request that moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff  <= 1'b0;
         fail_ff   <= 1'b0;
         bib_ff    <= '0;
         blocks_ff <= '0;
         idle_ff   <= '0;
         naks_ff   <= '0;
      end else if (stage.advance) begin
         armed_ff  <= armed_in;
         fail_ff   <= fail_in;
         bib_ff    <= bib_in;
         blocks_ff <= blocks_in;
         idle_ff   <= idle_in;
         naks_ff   <= naks_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ubbr_out_stage.sv =====
// ----------------------------------------------------------------------------
// ubbr_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ubbr_out_stage import ubbr_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire stage_type stage,
   input  wire rsp_type   result,
   output logic           out_free,
   ubbr_rsp_if.source     rsp_ch
);

   logic    valid_ff, valid_in;
   rsp_type rsp_ff, rsp_in;

   // Free when empty or when the held result is taken this cycle
   assign out_free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (out_free) begin
         valid_in = stage.valid;
         if (stage.advance) begin
            rsp_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.data_valid  = rsp_ff.data_valid;
   assign rsp_ch.data_out    = rsp_ff.data_out;
   assign rsp_ch.block_end   = rsp_ff.block_end;
   assign rsp_ch.reply       = rsp_ff.reply;
   assign rsp_ch.failed      = rsp_ff.failed;
   assign rsp_ch.blocks_done = rsp_ff.blocks_done;

endmodule

`default_nettype wire

// ===== test/ubbr_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ubbr_check
// Watches the request, result and register channels of the boot receiver,
// tracks the transfer state of its own and compares every result with the
// one predicted for the matching request.
// ----------------------------------------------------------------------------

module ubbr_check import ubbr_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   ubbr_req_if       req_w,
   ubbr_rsp_if       rsp_w,
   ubbr_csr_if       csr_w,
   output int        fail_count,
   output int        pending,
   output int        results_seen,
   output int        acks_seen,
   output int        naks_seen,
   output int        fails_seen
);

   // Register copies
   logic [TIMEOUT_W-1:0] timeout_cfg;
   logic [NAK_W-1:0]     nak_limit_cfg;

   // Transfer state
   logic                 armed;
   logic                 fail_flag;
   int                   byte_pos;
   logic [COUNT_W-1:0]   block_cnt;
   logic [COUNT_W-1:0]   idle_cnt;
   logic [NAK_W-1:0]     nak_cnt;

   // Results still owed by the block, oldest first
   rsp_type              owed_results [$];

   // Apply one request to the transfer state and return its result
   function automatic rsp_type advance_transfer(input logic [CMD_W-1:0] cmd,
                                                input logic [DATA_W-1:0] data);
      rsp_type r;
      logic    running;
      r       = '0;
      running = armed && !fail_flag;
      case (cmd)
         CMD_START: begin
            armed     = 1'b1;
            fail_flag = 1'b0;
            byte_pos  = 0;
            block_cnt = '0;
            idle_cnt  = '0;
            nak_cnt   = '0;
         end
         CMD_BYTE: begin
            if (running) begin
               r.data_valid = 1'b1;
               r.data_out   = data;
               idle_cnt     = '0;
               nak_cnt      = '0;
               if (byte_pos == BLOCK_BYTES - 1) begin
                  byte_pos    = 0;
                  r.block_end = 1'b1;
                  block_cnt   = block_cnt + 1'b1;
                  r.reply     = REPLY_ACK;
               end else begin
                  byte_pos = byte_pos + 1;
               end
            end
         end
         CMD_TICK: begin
            if (running) begin
               // Saturate the silence count, then test it against the timeout
               if (idle_cnt != IDLE_MAX) idle_cnt = idle_cnt + 1'b1;
               if (idle_cnt >= timeout_cfg) begin
                  idle_cnt = '0;
                  nak_cnt  = nak_cnt + 1'b1;
                  if (nak_cnt >= nak_limit_cfg) fail_flag = 1'b1;
                  else r.reply = REPLY_NAK;
               end
            end
         end
         default: ;
      endcase
      r.failed      = fail_flag;
      r.blocks_done = block_cnt;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      logic    was_failed;
      if (reset) begin
         timeout_cfg   = TIMEOUT_RESET;
         nak_limit_cfg = NAK_LIMIT_RESET;
         armed         = 1'b0;
         fail_flag     = 1'b0;
         byte_pos      = 0;
         block_cnt     = '0;
         idle_cnt      = '0;
         nak_cnt       = '0;
         owed_results.delete();
         fail_count    = 0;
         pending       = 0;
         results_seen  = 0;
         acks_seen     = 0;
         naks_seen     = 0;
         fails_seen    = 0;
      end else begin
         // Track register writes
         if (csr_w.valid && csr_w.ready) begin
            if (csr_w.index == REG_TIMEOUT) timeout_cfg = csr_w.wdata[TIMEOUT_W-1:0];
            else nak_limit_cfg = csr_w.wdata[NAK_W-1:0];
         end

         // Predict the result of an accepted request
         if (req_w.valid && req_w.ready) begin
            was_failed = fail_flag;
            want = advance_transfer(req_w.cmd, req_w.data);
            if (want.reply == REPLY_ACK) acks_seen++;
            if (want.reply == REPLY_NAK) naks_seen++;
            if (want.failed && !was_failed) fails_seen++;
            owed_results.push_back(want);
         end

         // Compare an accepted result with the oldest prediction
         if (rsp_w.valid && rsp_w.ready) begin
            got.data_valid  = rsp_w.data_valid;
            got.data_out    = rsp_w.data_out;
            got.block_end   = rsp_w.block_end;
            got.reply       = rsp_w.reply;
            got.failed      = rsp_w.failed;
            got.blocks_done = rsp_w.blocks_done;
            if (owed_results.size() == 0) begin
               if (fail_count < 10)
                  $display("%t: result with no request outstanding: valid=%0b data=%02h",
                           $realtime, got.data_valid, got.data_out);
               fail_count++;
            end else begin
               want = owed_results.pop_front();
               results_seen++;
               if ((got.data_valid  !== want.data_valid)  ||
                   (got.data_out    !== want.data_out)    ||
                   (got.block_end   !== want.block_end)   ||
                   (got.reply       !== want.reply)       ||
                   (got.failed      !== want.failed)      ||
                   (got.blocks_done !== want.blocks_done)) begin
                  if (fail_count < 10) begin
                     $display("%t: result mismatch, expected valid=%0b data=%02h end=%0b",
                              $realtime, want.data_valid, want.data_out, want.block_end);
                     $display("   reply=%0d failed=%0b blocks=%0d, got valid=%0b data=%02h",
                              want.reply, want.failed, want.blocks_done,
                              got.data_valid, got.data_out);
                     $display("   end=%0b reply=%0d failed=%0b blocks=%0d",
                              got.block_end, got.reply, got.failed, got.blocks_done);
                  end
                  fail_count++;
               end
            end
         end
         pending = owed_results.size();
      end
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the serial block boot receiver: a directed opening, then phases of
// random transfers under several timeout and nak limit settings, and one long
// silence at a larger timeout. The checker beside the block predicts and
// compares every result; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module tb;
   import ubbr_pkg::*;

   logic clock;
   logic reset;

   ubbr_req_if req_w ();
   ubbr_rsp_if rsp_w ();
   ubbr_csr_if csr_w ();

   int fail_count;
   int pending;
   int results_seen;
   int acks_seen;
   int naks_seen;
   int fails_seen;

   // Sender and receiver control
   int burst_left;
   int items_sent;
   bit fast_mode;
   bit hold_req;
   int hold_left;
   int stall_tick;
   int stall_mode;

   int unsigned phase_timeout [6];
   int unsigned phase_limit   [6];

   uart_block_boot_receiver_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_w),
      .rsp_ch (rsp_w),
      .csr_ch (csr_w)
   );

   ubbr_check u_check (
      .clock        (clock),
      .reset        (reset),
      .req_w        (req_w),
      .rsp_w        (rsp_w),
      .csr_w        (csr_w),
      .fail_count   (fail_count),
      .pending      (pending),
      .results_seen (results_seen),
      .acks_seen    (acks_seen),
      .naks_seen    (naks_seen),
      .fails_seen   (fails_seen)
   );

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Drop the run if it hangs
   initial begin
      #20ms;
      $display("timeout: requests or results stopped moving");
      $display("status: fail");
      $finish;
   end

   // Result side: stall on a changing pattern, with one long hold-off per random phase
   always @(negedge clock) begin
      stall_tick++;
      if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
         hold_left--;
         rsp_w.ready <= 1'b0;
      end else if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = 150;
         rsp_w.ready <= 1'b0;
      end else if (fast_mode) begin
         rsp_w.ready <= 1'b1;
      end else begin
         case (stall_mode)
            0:       rsp_w.ready <= 1'b1;
            1:       rsp_w.ready <= $urandom_range(0, 1);
            2:       rsp_w.ready <= (stall_tick % 4) != 3;
            default: rsp_w.ready <= (stall_tick % 4) == 0;
         endcase
      end
   end

   // Offer one request; entered and left at a falling edge
   task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] data);
      int gap;
      if (!fast_mode && burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            req_w.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_w.valid <= 1'b1;
      req_w.cmd   <= cmd;
      req_w.data  <= data;
      @(posedge clock);
      while (!req_w.ready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) burst_left--;
      items_sent++;
   endtask

   // Stop offering requests
   task automatic end_reqs();
      req_w.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Write a register once every result is back
   task automatic set_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DAT_W-1:0] wdata);
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_w.valid <= 1'b1;
      csr_w.index <= index;
      csr_w.wdata <= wdata;
      @(posedge clock);
      while (!csr_w.ready) @(posedge clock);
      @(negedge clock);
      csr_w.valid <= 1'b0;
   endtask

   // Random transfers: mostly runs of bytes, with silences, restarts and noise
   task automatic run_traffic(input int count, input int tick_run_max);
      int first;
      int pick;
      int len;
      first = items_sent;
      send_req(CMD_START, $urandom_range(0, 255));
      while (items_sent - first < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            len = $urandom_range(1, 70);
            repeat (len) begin
               if ($urandom_range(0, 9) == 0) send_req(CMD_TICK, $urandom_range(0, 255));
               else send_req(CMD_BYTE, $urandom_range(0, 255));
            end
         end else if (pick < 80) begin
            len = $urandom_range(1, tick_run_max);
            repeat (len) send_req(CMD_TICK, $urandom_range(0, 255));
            if ($urandom_range(0, 1)) send_req(CMD_START, $urandom_range(0, 255));
         end else if (pick < 88) begin
            send_req(CMD_START, $urandom_range(0, 255));
         end else if (pick < 94) begin
            send_req(CMD_SPARE, $urandom_range(0, 255));
         end else begin
            send_req($urandom_range(0, 3), $urandom_range(0, 255));
         end
      end
      end_reqs();
   endtask

   // Main sequence
   initial begin
      int tick_max;
      reset       = 1'b1;
      req_w.valid = 1'b0;
      req_w.cmd   = CMD_START;
      req_w.data  = '0;
      rsp_w.ready = 1'b0;
      csr_w.valid = 1'b0;
      csr_w.index = REG_TIMEOUT;
      csr_w.wdata = '0;
      burst_left  = 0;
      items_sent  = 0;
      fast_mode   = 1'b0;
      hold_req    = 1'b0;
      hold_left   = 0;
      stall_tick  = 0;
      stall_mode  = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Not started: drop everything but a start
      send_req(CMD_BYTE, 8'hFF);
      send_req(CMD_TICK, 8'h00);
      send_req(CMD_SPARE, 8'hFF);
      // Running with reset settings: extremes of the byte, unused command, restart
      send_req(CMD_START, 8'h00);
      send_req(CMD_BYTE, 8'h00);
      send_req(CMD_BYTE, 8'hFF);
      send_req(CMD_BYTE, 8'hA5);
      send_req(CMD_BYTE, 8'h5A);
      send_req(CMD_SPARE, 8'h00);
      repeat (3) send_req(CMD_TICK, 8'h00);
      send_req(CMD_START, 8'hFF);
      send_req(CMD_BYTE, 8'h3C);
      end_reqs();

      // Short timeout: nak, then fail, then ignore until restarted
      set_reg(REG_TIMEOUT, 16'd1);
      set_reg(REG_NAK_LIMIT, 16'd2);
      send_req(CMD_START, 8'h00);
      send_req(CMD_TICK, 8'h00);
      send_req(CMD_TICK, 8'h00);
      send_req(CMD_BYTE, 8'h77);
      send_req(CMD_TICK, 8'h00);
      send_req(CMD_START, 8'h00);
      send_req(CMD_BYTE, 8'hC3);
      end_reqs();

      // Random phases, zero timeout and zero nak limit among them
      phase_timeout = '{3, 1, 0, 4, 2, $urandom_range(1, 9)};
      phase_limit   = '{3, 1, 2, 0, 15, $urandom_range(1, 15)};
      foreach (phase_timeout[i]) begin
         set_reg(REG_TIMEOUT, 16'(phase_timeout[i]));
         set_reg(REG_NAK_LIMIT, {12'($urandom_range(0, 4095)), 4'(phase_limit[i])});
         tick_max = int'(phase_timeout[i] * phase_limit[i]) + 3;
         if (tick_max > 40) tick_max = 40;
         hold_req = 1'b1;
         run_traffic(150, tick_max);
      end

      // Long silence at a larger timeout: one nak after 200 ticks
      set_reg(REG_TIMEOUT, 16'd200);
      set_reg(REG_NAK_LIMIT, 16'h000F);
      fast_mode = 1'b1;
      send_req(CMD_START, 8'h00);
      repeat (199) send_req(CMD_TICK, 8'h00);
      send_req(CMD_TICK, 8'h00);
      send_req(CMD_BYTE, 8'h81);
      end_reqs();
      fast_mode = 1'b0;

      // Drain and let any stray result show
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("covered %0d requests over reset, directed and random register settings",
               items_sent);
      $display("compared %0d results: %0d block acks, %0d naks, %0d failed transfers",
               results_seen, acks_seen, naks_seen, fails_seen);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
